[hw/rtl/exposure_zone_weights_macros.svh]
// assertion helpers for the exposure zone weight checker
`ifndef EXPOSURE_ZONE_WEIGHTS_MACROS_SVH
`define EXPOSURE_ZONE_WEIGHTS_MACROS_SVH

// condition must hold whenever out of reset
`define EZW_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("exposure zone weights: property failed");

// antecedent implies consequent in the same cycle
`define EZW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("exposure zone weights: implication failed");

`endif

[hw/rtl/ezw_pkg.sv]
`timescale 1ns / 1ps
package ezw_pkg;

   localparam int LUMA_W    = 24;
   localparam int OUT_W     = 16;
   localparam int ZONES     = 7;
   localparam int LOG_STEPS = 16;
   localparam int EXP_W     = 5;
   localparam int MANT_W    = 31;
   localparam int LOG_W     = EXP_W + LOG_STEPS;
   localparam int EV_W      = LOG_W + 1;
   localparam int DELTA_W   = EV_W + 1;
   localparam int ABS_W     = 21;
   localparam int D2_W      = 26;
   localparam int T_W       = 20;
   localparam int T_FRAC    = 10;
   localparam int IP_W      = 5;
   localparam int WQ_W      = 25;
   localparam int TAB_W     = 24;
   localparam int SUM_W     = 27;

   localparam int STEP_Q16    = 98304;
   localparam int GAUSS_SCALE = 65431;
   localparam int T_LIMIT     = 25 << T_FRAC;
   localparam logic [WQ_W-1:0] ONE_Q24 = WQ_W'(1) << TAB_W;

   localparam int LUMA_FRAC_BITS_DEF   = 16;
   localparam int WEIGHT_FRAC_BITS_DEF = 15;

   // registers from the log pipeline entry to the result register, not counting the divider stages
   localparam int BASE_LATENCY = 35;

   typedef logic [WQ_W-1:0] weight_q_type;

   typedef struct packed {
      logic             valid;
      logic [LOG_W-1:0] luma_log;
      logic [LOG_W-1:0] anchor_log;
   } log_out_type;

   typedef struct packed {
      logic                         valid;
      weight_q_type [ZONES-1:0]     weight;
   } zone_out_type;

   // 2^-(2^-(i+1)) in Q24
   function automatic logic [TAB_W-1:0] exp2_neg(input logic [3:0] i);
      logic [TAB_W-1:0] v;
      case (i)
         4'd0:    v = 24'd11863283;
         4'd1:    v = 24'd14107901;
         4'd2:    v = 24'd15384775;
         4'd3:    v = 24'd16065917;
         4'd4:    v = 24'd16417715;
         4'd5:    v = 24'd16596492;
         4'd6:    v = 24'd16686609;
         4'd7:    v = 24'd16731851;
         4'd8:    v = 24'd16754518;
         4'd9:    v = 24'd16765863;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [EXP_W-1:0] lead_one(input logic [LUMA_W-1:0] x);
      logic [EXP_W-1:0] e;
      e = '0;
      for (int i = 0; i < LUMA_W; i++) begin
         if (x[i]) begin
            e = EXP_W'(i);
         end
      end
      return e;
   endfunction

   function automatic logic signed [DELTA_W-1:0] zone_centre(input int k);
      return DELTA_W'((k - 3) * STEP_Q16);
   endfunction

   function automatic int latency(input int weight_frac_bits);
      return BASE_LATENCY + weight_frac_bits + 1;
   endfunction

endpackage

[hw/rtl/ezw_log2.sv]
`timescale 1ns / 1ps
module ezw_log2 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        valid_in,
   input  logic [ezw_pkg::LUMA_W-1:0]  luma,
   input  logic [ezw_pkg::LUMA_W-1:0]  anchor,
   output ezw_pkg::log_out_type        log_out
);
   import ezw_pkg::*;

   localparam int LANES = 2;

   logic [LUMA_W-1:0]    src [LANES];
   logic [LUMA_W-1:0]    src_nz [LANES];
   logic [EXP_W-1:0]     e_lead [LANES];
   logic [MANT_W-1:0]    mant0_in [LANES];
   logic [2*MANT_W-1:0]  sq [LOG_STEPS][LANES];
   logic [MANT_W-1:0]    mant_in [LOG_STEPS][LANES];
   logic [LOG_STEPS-1:0] frac_in [LOG_STEPS][LANES];

   logic                 valid_ff [LOG_STEPS+1];
   logic [EXP_W-1:0]     exp_ff [LOG_STEPS+1][LANES];
   logic [MANT_W-1:0]    mant_ff [LOG_STEPS+1][LANES];
   logic [LOG_STEPS-1:0] frac_ff [LOG_STEPS+1][LANES];

   assign src[0] = luma;
   assign src[1] = anchor;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         src_nz[l]   = (src[l] == '0) ? LUMA_W'(1) : src[l];
         e_lead[l]   = lead_one(src_nz[l]);
         // normalise so the leading one sits at bit 30
         mant0_in[l] = MANT_W'(src_nz[l]) << (EXP_W'(MANT_W - 1) - e_lead[l]);
      end
      // one squaring per stage yields one fraction bit
      for (int s = 0; s < LOG_STEPS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            sq[s][l] = (2*MANT_W)'(mant_ff[s][l]) * (2*MANT_W)'(mant_ff[s][l]);
            if (sq[s][l][2*MANT_W-1]) begin
               mant_in[s][l] = sq[s][l][2*MANT_W-1:MANT_W];
            end else begin
               mant_in[s][l] = sq[s][l][2*MANT_W-2:MANT_W-1];
            end
            frac_in[s][l] = {frac_ff[s][l][LOG_STEPS-2:0], sq[s][l][2*MANT_W-1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LOG_STEPS; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= valid_in;
         for (int s = 1; s <= LOG_STEPS; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         exp_ff[0][l]  <= e_lead[l];
         mant_ff[0][l] <= mant0_in[l];
         frac_ff[0][l] <= '0;
         for (int s = 1; s <= LOG_STEPS; s++) begin
            exp_ff[s][l]  <= exp_ff[s-1][l];
            mant_ff[s][l] <= mant_in[s-1][l];
            frac_ff[s][l] <= frac_in[s-1][l];
         end
      end
   end

   assign log_out.valid      = valid_ff[LOG_STEPS];
   assign log_out.luma_log   = {exp_ff[LOG_STEPS][0], frac_ff[LOG_STEPS][0]};
   assign log_out.anchor_log = {exp_ff[LOG_STEPS][1], frac_ff[LOG_STEPS][1]};

endmodule

[hw/rtl/ezw_gauss.sv]
`timescale 1ns / 1ps
module ezw_gauss (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid_in,
   input  logic signed [ezw_pkg::EV_W-1:0]   ev,
   output ezw_pkg::zone_out_type             zone_out
);
   import ezw_pkg::*;

   localparam int XS = T_FRAC;

   logic signed [DELTA_W-1:0] delta [ZONES];
   logic [2*ABS_W-1:0]        ad_sq [ZONES];
   logic [D2_W+16-1:0]        d2_prod [ZONES];
   logic [T_W-1:0]            t_val [ZONES];
   logic [WQ_W+TAB_W-1:0]     w_prod [XS][ZONES];
   logic [WQ_W-1:0]           w_in [XS][ZONES];

   // front stages
   logic              valid_ff [3];
   logic [ABS_W-1:0]  ad_ff [ZONES];
   logic [D2_W-1:0]   d2_ff [ZONES];
   logic              clamp0_ff [ZONES];
   logic              clamp1_ff [ZONES];
   logic              clamp2_ff [ZONES];
   logic              zero2_ff [ZONES];
   logic [IP_W-1:0]   ip2_ff [ZONES];
   logic [T_FRAC-1:0] frac2_ff [ZONES];

   // exp2 stages, one fraction bit each
   logic              xvalid_ff [XS];
   logic [WQ_W-1:0]   w_ff [XS][ZONES];
   logic              xclamp_ff [XS][ZONES];
   logic              xzero_ff [XS][ZONES];
   logic [IP_W-1:0]   xip_ff [XS][ZONES];
   logic [T_FRAC-1:0] xfrac_ff [XS][ZONES];

   logic              out_valid_ff;
   weight_q_type      out_w_ff [ZONES];

   always_comb begin
      for (int k = 0; k < ZONES; k++) begin
         delta[k]   = DELTA_W'(ev) - zone_centre(k);
         ad_sq[k]   = (2*ABS_W)'(ad_ff[k]) * (2*ABS_W)'(ad_ff[k]);
         d2_prod[k] = (D2_W+16)'(d2_ff[k]) * (D2_W+16)'(GAUSS_SCALE);
         t_val[k]   = d2_prod[k][D2_W+16-1:22];
      end
      for (int k = 0; k < ZONES; k++) begin
         w_prod[0][k] = (WQ_W+TAB_W)'(ONE_Q24) * (WQ_W+TAB_W)'(exp2_neg(4'd0));
         w_in[0][k]   = frac2_ff[k][T_FRAC-1] ? w_prod[0][k][WQ_W+TAB_W-1:TAB_W] : ONE_Q24;
         for (int j = 1; j < XS; j++) begin
            w_prod[j][k] = (WQ_W+TAB_W)'(w_ff[j-1][k]) * (WQ_W+TAB_W)'(exp2_neg(4'(j)));
            w_in[j][k]   = xfrac_ff[j-1][k][T_FRAC-1-j] ?
                           w_prod[j][k][WQ_W+TAB_W-1:TAB_W] : w_ff[j-1][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            valid_ff[i] <= 1'b0;
         end
         for (int j = 0; j < XS; j++) begin
            xvalid_ff[j] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff[0]  <= valid_in;
         valid_ff[1]  <= valid_ff[0];
         valid_ff[2]  <= valid_ff[1];
         xvalid_ff[0] <= valid_ff[2];
         for (int j = 1; j < XS; j++) begin
            xvalid_ff[j] <= xvalid_ff[j-1];
         end
         out_valid_ff <= xvalid_ff[XS-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ZONES; k++) begin
         ad_ff[k]     <= delta[k][DELTA_W-1] ? ABS_W'(-delta[k]) : ABS_W'(delta[k]);
         // outer zones saturate to full weight beyond their centre
         clamp0_ff[k] <= ((k == 0) && (delta[k] <= 0)) || ((k == ZONES-1) && (delta[k] >= 0));
         d2_ff[k]     <= ad_sq[k][2*ABS_W-1:16];
         clamp1_ff[k] <= clamp0_ff[k];
         zero2_ff[k]  <= (t_val[k] >= T_W'(T_LIMIT));
         ip2_ff[k]    <= t_val[k][T_FRAC+IP_W-1:T_FRAC];
         frac2_ff[k]  <= t_val[k][T_FRAC-1:0];
         clamp2_ff[k] <= clamp1_ff[k];

         w_ff[0][k]      <= w_in[0][k];
         xclamp_ff[0][k] <= clamp2_ff[k];
         xzero_ff[0][k]  <= zero2_ff[k];
         xip_ff[0][k]    <= ip2_ff[k];
         xfrac_ff[0][k]  <= frac2_ff[k];
         for (int j = 1; j < XS; j++) begin
            w_ff[j][k]      <= w_in[j][k];
            xclamp_ff[j][k] <= xclamp_ff[j-1][k];
            xzero_ff[j][k]  <= xzero_ff[j-1][k];
            xip_ff[j][k]    <= xip_ff[j-1][k];
            xfrac_ff[j][k]  <= xfrac_ff[j-1][k];
         end

         if (xclamp_ff[XS-1][k]) begin
            out_w_ff[k] <= ONE_Q24;
         end else if (xzero_ff[XS-1][k]) begin
            out_w_ff[k] <= '0;
         end else begin
            out_w_ff[k] <= w_ff[XS-1][k] >> xip_ff[XS-1][k];
         end
      end
   end

   always_comb begin
      zone_out.valid = out_valid_ff;
      for (int k = 0; k < ZONES; k++) begin
         zone_out.weight[k] = out_w_ff[k];
      end
   end

endmodule

[hw/rtl/exposure_zone_weights.sv]
`timescale 1ns / 1ps
// Per-pixel exposure zone weights. One luminance sample may be started in every clock
// cycle and busy never rises; each sample gives one result, shown with rsp_strobe for a
// single cycle. The receiver cannot stall the block. The result passes through the sixteen
// squaring stages of the log2 pipeline, the ten-stage exp2 chain of the zone weights and
// the one-bit-per-stage normalising divider.
// A write to csr_wdata takes effect for the next sample started.
module exposure_zone_weights #(
   parameter int LUMA_FRAC_BITS   = ezw_pkg::LUMA_FRAC_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = ezw_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [ezw_pkg::LUMA_W-1:0]  req_luma_sample,
   input  logic                        csr_we,
   input  logic [ezw_pkg::LUMA_W-1:0]  csr_wdata,
   output logic                        rsp_strobe,
   output logic [ezw_pkg::OUT_W-1:0]   rsp_weight_zone0,
   output logic [ezw_pkg::OUT_W-1:0]   rsp_weight_zone1,
   output logic [ezw_pkg::OUT_W-1:0]   rsp_weight_zone2,
   output logic [ezw_pkg::OUT_W-1:0]   rsp_weight_zone3,
   output logic [ezw_pkg::OUT_W-1:0]   rsp_weight_zone4,
   output logic [ezw_pkg::OUT_W-1:0]   rsp_weight_zone5,
   output logic [ezw_pkg::OUT_W-1:0]   rsp_weight_zone6
);
   import ezw_pkg::*;

   localparam logic [LUMA_W-1:0] ANCHOR_RESET = LUMA_W'((64'd18 << LUMA_FRAC_BITS) / 64'd100);
   localparam int QB    = WEIGHT_FRAC_BITS + 1;
   localparam int NUM_W = WQ_W + WEIGHT_FRAC_BITS;
   localparam int QX    = (QB > OUT_W) ? QB : OUT_W;

   logic [LUMA_W-1:0] anchor_ff;
   log_out_type       log_out;
   zone_out_type      zone_out;

   logic                   ev_valid_ff;
   logic signed [EV_W-1:0] ev_ff;

   logic [SUM_W-1:0] sum_acc;
   logic             sum_valid_ff;
   logic [SUM_W-1:0] sum_ff;
   weight_q_type     ws_ff [ZONES];

   logic [NUM_W-1:0] num [ZONES];
   logic             prep_valid_ff;
   logic [SUM_W-1:0] prep_sum_ff;
   logic [SUM_W-1:0] prep_rem_ff [ZONES];
   logic [QB-1:0]    prep_low_ff [ZONES];

   logic [SUM_W:0]   r2 [QB][ZONES];
   logic             ge [QB][ZONES];
   logic [SUM_W-1:0] rem_in [QB][ZONES];

   logic             dvalid_ff [QB];
   logic [SUM_W-1:0] dsum_ff [QB];
   logic [SUM_W-1:0] rem_ff [QB][ZONES];
   logic [QB-1:0]    low_ff [QB][ZONES];
   logic [QB-1:0]    q_ff [QB][ZONES];

   logic [QX-1:0]    qx [ZONES];
   logic             out_valid_ff;
   logic [OUT_W-1:0] out_ff [ZONES];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_ff <= ANCHOR_RESET;
      end else if (csr_we) begin
         anchor_ff <= csr_wdata;
      end
   end

   // the anchor rides along with the sample so a new setting never meets an old sample
   ezw_log2 u_log2 (
      .clock    (clock),
      .reset    (reset),
      .valid_in (start && !busy),
      .luma     (req_luma_sample),
      .anchor   (anchor_ff),
      .log_out  (log_out)
   );

   always_ff @(posedge clock) begin
      ev_ff <= $signed({1'b0, log_out.luma_log}) - $signed({1'b0, log_out.anchor_log});
   end

   ezw_gauss u_gauss (
      .clock    (clock),
      .reset    (reset),
      .valid_in (ev_valid_ff),
      .ev       (ev_ff),
      .zone_out (zone_out)
   );

   always_comb begin
      sum_acc = '0;
      for (int k = 0; k < ZONES; k++) begin
         sum_acc = sum_acc + SUM_W'(zone_out.weight[k]);
      end
      for (int k = 0; k < ZONES; k++) begin
         num[k] = (NUM_W'(ws_ff[k]) << WEIGHT_FRAC_BITS) + NUM_W'(sum_ff >> 1);
      end
      // restoring division, one quotient bit per stage
      for (int j = 0; j < QB; j++) begin
         for (int k = 0; k < ZONES; k++) begin
            if (j == 0) begin
               r2[j][k] = {prep_rem_ff[k], prep_low_ff[k][QB-1]};
               ge[j][k] = (r2[j][k] >= {1'b0, prep_sum_ff});
               rem_in[j][k] = ge[j][k] ? SUM_W'(r2[j][k] - {1'b0, prep_sum_ff})
                                       : SUM_W'(r2[j][k]);
            end else begin
               r2[j][k] = {rem_ff[j-1][k], low_ff[j-1][k][QB-1]};
               ge[j][k] = (r2[j][k] >= {1'b0, dsum_ff[j-1]});
               rem_in[j][k] = ge[j][k] ? SUM_W'(r2[j][k] - {1'b0, dsum_ff[j-1]})
                                       : SUM_W'(r2[j][k]);
            end
         end
      end
      for (int k = 0; k < ZONES; k++) begin
         qx[k] = QX'(q_ff[QB-1][k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff   <= 1'b0;
         sum_valid_ff  <= 1'b0;
         prep_valid_ff <= 1'b0;
         for (int j = 0; j < QB; j++) begin
            dvalid_ff[j] <= 1'b0;
         end
         out_valid_ff  <= 1'b0;
      end else begin
         ev_valid_ff   <= log_out.valid;
         sum_valid_ff  <= zone_out.valid;
         prep_valid_ff <= sum_valid_ff;
         dvalid_ff[0]  <= prep_valid_ff;
         for (int j = 1; j < QB; j++) begin
            dvalid_ff[j] <= dvalid_ff[j-1];
         end
         out_valid_ff  <= dvalid_ff[QB-1];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= (sum_acc == '0) ? SUM_W'(1) : sum_acc;
      prep_sum_ff <= sum_ff;
      dsum_ff[0]  <= prep_sum_ff;
      for (int j = 1; j < QB; j++) begin
         dsum_ff[j] <= dsum_ff[j-1];
      end
      for (int k = 0; k < ZONES; k++) begin
         ws_ff[k]       <= zone_out.weight[k];
         prep_rem_ff[k] <= SUM_W'(num[k] >> QB);
         prep_low_ff[k] <= num[k][QB-1:0];
         rem_ff[0][k]   <= rem_in[0][k];
         low_ff[0][k]   <= prep_low_ff[k] << 1;
         q_ff[0][k]     <= QB'(ge[0][k]);
         for (int j = 1; j < QB; j++) begin
            rem_ff[j][k] <= rem_in[j][k];
            low_ff[j][k] <= low_ff[j-1][k] << 1;
            q_ff[j][k]   <= {q_ff[j-1][k][QB-2:0], ge[j][k]};
         end
         out_ff[k] <= (qx[k] > QX'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : qx[k][OUT_W-1:0];
      end
   end

   assign rsp_strobe       = out_valid_ff;
   assign rsp_weight_zone0 = out_ff[0];
   assign rsp_weight_zone1 = out_ff[1];
   assign rsp_weight_zone2 = out_ff[2];
   assign rsp_weight_zone3 = out_ff[3];
   assign rsp_weight_zone4 = out_ff[4];
   assign rsp_weight_zone5 = out_ff[5];
   assign rsp_weight_zone6 = out_ff[6];

endmodule

[hw/rtl/ezw_checker.sv]
`timescale 1ns / 1ps
`include "exposure_zone_weights_macros.svh"
module ezw_checker #(
   parameter int WEIGHT_FRAC_BITS = ezw_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_strobe,
   input logic [ezw_pkg::OUT_W-1:0]  rsp_weight_zone0,
   input logic [ezw_pkg::OUT_W-1:0]  rsp_weight_zone1,
   input logic [ezw_pkg::OUT_W-1:0]  rsp_weight_zone2,
   input logic [ezw_pkg::OUT_W-1:0]  rsp_weight_zone3,
   input logic [ezw_pkg::OUT_W-1:0]  rsp_weight_zone4,
   input logic [ezw_pkg::OUT_W-1:0]  rsp_weight_zone5,
   input logic [ezw_pkg::OUT_W-1:0]  rsp_weight_zone6
);
   import ezw_pkg::*;

   localparam int LAT = latency(WEIGHT_FRAC_BITS);
   localparam int TW  = OUT_W + 3;
   localparam logic [TW-1:0] UNITY = TW'(1) << WEIGHT_FRAC_BITS;
   localparam logic [TW-1:0] SLACK = TW'(4);

   logic [TW-1:0] total;

   assign total = TW'(rsp_weight_zone0) + TW'(rsp_weight_zone1) + TW'(rsp_weight_zone2)
                + TW'(rsp_weight_zone3) + TW'(rsp_weight_zone4) + TW'(rsp_weight_zone5)
                + TW'(rsp_weight_zone6);

   // every result belongs to a sample started a fixed time earlier
   `EZW_ASSERT_IMPLY(a_result_latency, clock, reset, rsp_strobe, $past(start && !busy, LAT))

   // rounded weights add up to one within the rounding of seven terms
   `EZW_ASSERT_IMPLY(a_weight_sum, clock, reset, rsp_strobe && (WEIGHT_FRAC_BITS < OUT_W), (total >= UNITY - SLACK) && (total <= UNITY + SLACK))

   `EZW_ASSERT_ALWAYS(a_zone_range, clock, reset, !rsp_strobe || (WEIGHT_FRAC_BITS >= OUT_W) || (TW'(rsp_weight_zone0) <= UNITY && TW'(rsp_weight_zone3) <= UNITY && TW'(rsp_weight_zone6) <= UNITY))

endmodule

bind exposure_zone_weights ezw_checker #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_ezw_checker (.*);
